/* rtl/line_follow_obstacle_avoid_sequencer_assert.svh */
// Assertion macros for the line-follow / obstacle-avoid sequencer.
`ifndef LINE_FOLLOW_OBSTACLE_AVOID_SEQUENCER_ASSERT_SVH
`define LINE_FOLLOW_OBSTACLE_AVOID_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge, off during reset.
`define LFOAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must hold at every rising clock edge.
`define LFOAS_INVARIANT(lbl, cond, msg) `LFOAS_ASSERT(lbl, cond, msg)
`else
`define LFOAS_ASSERT(lbl, prop, msg)
`define LFOAS_INVARIANT(lbl, cond, msg)
`endif
`endif

/* rtl/lfoas_pkg.sv */
// Types and constants shared by the sequencer modules.
package lfoas_pkg;

  typedef enum logic [2:0] {
    MODE_STOP       = 3'd0,
    MODE_FWD        = 3'd1,
    MODE_BACK       = 3'd2,
    MODE_SPIN_LEFT  = 3'd3,
    MODE_SPIN_RIGHT = 3'd4,
    MODE_VEER_LEFT  = 3'd5,
    MODE_VEER_RIGHT = 3'd6
  } mode_e;

  // Avoidance sequence steps
  localparam logic [3:0] STEP_BACKUP      = 4'd0;
  localparam logic [3:0] STEP_BACKUP_WAIT = 4'd1;
  localparam logic [3:0] STEP_TURN_R      = 4'd2;
  localparam logic [3:0] STEP_TURN_R_WAIT = 4'd3;
  localparam logic [3:0] STEP_FWD_LONG    = 4'd4;
  localparam logic [3:0] STEP_FWD_LONG_WT = 4'd5;
  localparam logic [3:0] STEP_TURN_L_WAIT = 4'd6;
  localparam logic [3:0] STEP_FWD_SHORT   = 4'd7;
  localparam logic [3:0] STEP_FWD_SHRT_WT = 4'd8;
  localparam logic [3:0] STEP_FINAL_WAIT  = 4'd9;
  localparam logic [3:0] STEP_LAST        = STEP_FINAL_WAIT;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_CRUISE    = 3'd1;
  localparam logic [2:0] REG_SLOW      = 3'd2;
  localparam logic [2:0] REG_TURN      = 3'd3;
  localparam logic [2:0] REG_INTERVAL  = 3'd4;

  // Register reset values
  localparam logic [9:0]  THRESHOLD_RST = 10'd25;
  localparam logic [7:0]  CRUISE_RST    = 8'd180;
  localparam logic [7:0]  SLOW_RST      = 8'd120;
  localparam logic [15:0] TURN_RST      = 16'd400;
  localparam logic [15:0] INTERVAL_RST  = 16'd30;

  // Fixed speeds, distances and durations
  localparam logic [9:0]  RIGHT_DIST_CM   = 10'd300;
  localparam logic [7:0]  TURN_SPEED      = 8'd200;
  localparam logic [7:0]  LEFT_FIX_SPEED  = 8'd160;
  localparam logic [31:0] RIGHT_FIX_MS    = 32'd100;
  localparam logic [31:0] LEFT_FIX_MS     = 32'd80;
  localparam logic [31:0] SHORT_FWD_MS    = 32'd200;
  localparam logic [31:0] BACKUP_MS       = 32'd500;
  localparam logic [31:0] LONG_FWD_MS     = 32'd1100;
  localparam logic [31:0] LONG_FWD_WAIT   = 32'd1000;
  localparam logic [31:0] LEFT_EXTRA_MS   = 32'd50;
  localparam logic [31:0] SLOW_FWD_MS     = 32'd400;

  typedef struct packed {
    logic [9:0]  threshold;
    logic [7:0]  cruise;
    logic [7:0]  slow;
    logic [15:0] turn_ms;
    logic [15:0] interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        line_right_black;
    logic        line_middle_black;
    logic        line_left_black;
    logic [9:0]  dist_left_cm;
    logic [9:0]  dist_center_cm;
  } item_t;

  typedef struct packed {
    mode_e      motor_mode;
    logic [7:0] motor_speed;
    logic       moving;
    logic       command_changed;
    logic       avoiding;
    logic [3:0] sequence_step;
  } result_t;

endpackage

/* rtl/line_follow_obstacle_avoid_sequencer.sv */
// Top level of the line-follow / obstacle-avoid sequencer.
//
// Channel   Dir  Handshake               Contents
// s_axis    in   tvalid/tready           one control-loop pass (time, line bits, distances)
// m_axis    out  tvalid/tready           motor command and avoidance state
// APB       in   psel/penable/pwrite     five tuning registers at 0x00..0x10
//
// One item per cycle unless the output stalls; order: input register, result register.
// Each item updates the motion and sequence state in the cycle it leaves the input register.
// A stalled result register holds the input register; the input side stays ready while
// the input register is empty or moving on.
// Reset clears valid flags and control state and loads register defaults; no clearing pass.
module line_follow_obstacle_avoid_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] now_ms, [32] line_right_black, [33] line_middle_black,
  // [34] line_left_black, [44:35] dist_left_cm, [54:45] dist_center_cm, [55] zero
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] motor_mode, [10:3] motor_speed, [11] moving, [12] command_changed,
  // [13] avoiding, [17:14] sequence_step, [23:18] zero
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfoas_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res_d, out_res_q;
  logic    out_valid_q;
  logic    advance;
  logic    fire;
  logic    cfg_wr;
  logic [2:0] reg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= THRESHOLD_RST;
      cfg_q.cruise      <= CRUISE_RST;
      cfg_q.slow        <= SLOW_RST;
      cfg_q.turn_ms     <= TURN_RST;
      cfg_q.interval_ms <= INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg_q.threshold   <= pwdata[9:0];
        REG_CRUISE:    cfg_q.cruise      <= pwdata[7:0];
        REG_SLOW:      cfg_q.slow        <= pwdata[7:0];
        REG_TURN:      cfg_q.turn_ms     <= pwdata[15:0];
        REG_INTERVAL:  cfg_q.interval_ms <= pwdata[15:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = 32'(cfg_q.threshold);
      REG_CRUISE:    prdata = 32'(cfg_q.cruise);
      REG_SLOW:      prdata = 32'(cfg_q.slow);
      REG_TURN:      prdata = 32'(cfg_q.turn_ms);
      REG_INTERVAL:  prdata = 32'(cfg_q.interval_ms);
      default:       prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  // Result register frees up when empty or being taken this cycle.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.now_ms            <= s_axis_tdata[31:0];
      in_item_q.line_right_black  <= s_axis_tdata[32];
      in_item_q.line_middle_black <= s_axis_tdata[33];
      in_item_q.line_left_black   <= s_axis_tdata[34];
      in_item_q.dist_left_cm      <= s_axis_tdata[44:35];
      in_item_q.dist_center_cm    <= s_axis_tdata[54:45];
    end
  end

  // ---------------- control pass ----------------
  lfoas_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cfg_i  (cfg_q),
    .item_i (in_item_q),
    .res_o  (res_d)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.sequence_step, out_res_q.avoiding,
                          out_res_q.command_changed, out_res_q.moving,
                          out_res_q.motor_speed, out_res_q.motor_mode};

  // ---------------- assertions ----------------
`include "line_follow_obstacle_avoid_sequencer_assert.svh"

  // a running motion always carries a non-stop mode, and a stopped one none
  `LFOAS_INVARIANT(a_moving_matches_mode,
                   !out_valid_q || (out_res_q.moving == (out_res_q.motor_mode != MODE_STOP)),
                   "moving flag disagrees with motor mode")
  // sequence step never leaves the defined range
  `LFOAS_INVARIANT(a_step_in_range,
                   !out_valid_q || (out_res_q.sequence_step <= STEP_LAST),
                   "sequence step out of range")
  // a held input item is not dropped while the result side stalls
  `LFOAS_ASSERT(a_input_held, (in_valid_q && !fire) |=> in_valid_q, "input item lost under stall")

endmodule

/* rtl/lfoas_ctrl.sv */
// Motion state, line corrector and avoidance sequence: one pass per fire.
module lfoas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  lfoas_pkg::cfg_t   cfg_i,
  input  lfoas_pkg::item_t  item_i,
  output lfoas_pkg::result_t res_o
);
  import lfoas_pkg::*;

  mode_e       mode_q, mode_d;
  logic [7:0]  speed_q, speed_d;
  logic [31:0] end_q, end_d;
  logic        run_q, run_d;
  logic [31:0] last_q, last_d;
  logic        avoid_q, avoid_d;
  logic        early_q, early_d;
  logic [3:0]  step_q, step_d;
  logic [31:0] step_end_q, step_end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STOP;
      speed_q    <= '0;
      end_q      <= '0;
      run_q      <= 1'b0;
      last_q     <= '0;
      avoid_q    <= 1'b0;
      early_q    <= 1'b0;
      step_q     <= STEP_BACKUP;
      step_end_q <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      speed_q    <= speed_d;
      end_q      <= end_d;
      run_q      <= run_d;
      last_q     <= last_d;
      avoid_q    <= avoid_d;
      early_q    <= early_d;
      step_q     <= step_d;
      step_end_q <= step_end_d;
    end
  end

  always_comb begin
    logic [31:0] now;
    logic [31:0] turn32;
    logic        chg;
    logic        step_done;
    logic        obstacle;
    now        = item_i.now_ms;
    turn32     = 32'(cfg_i.turn_ms);
    mode_d     = mode_q;
    speed_d    = speed_q;
    end_d      = end_q;
    run_d      = run_q;
    last_d     = last_q;
    avoid_d    = avoid_q;
    early_d    = early_q;
    step_d     = step_q;
    step_end_d = step_end_q;
    chg        = 1'b0;

    // timed motion expiry
    if (run_d && now >= end_d) begin
      run_d  = 1'b0;
      mode_d = MODE_STOP;
      chg    = 1'b1;
    end

    // throttled line corrector
    if (!early_d && ((now - last_d) >= 32'(cfg_i.interval_ms))) begin
      last_d = now;
      if (item_i.line_right_black) begin
        mode_d = MODE_SPIN_RIGHT; speed_d = TURN_SPEED; end_d = now + RIGHT_FIX_MS;
        run_d = 1'b1; chg = 1'b1;
      end else if (item_i.line_middle_black) begin
        if (!run_d || mode_d != MODE_FWD) begin
          mode_d = MODE_FWD; speed_d = cfg_i.cruise; end_d = now + SHORT_FWD_MS;
          run_d = 1'b1; chg = 1'b1;
        end
      end else if (item_i.line_left_black) begin
        mode_d = MODE_SPIN_LEFT; speed_d = LEFT_FIX_SPEED; end_d = now + LEFT_FIX_MS;
        run_d = 1'b1; chg = 1'b1;
      end else if (!run_d && !avoid_d) begin
        mode_d = MODE_VEER_LEFT; speed_d = cfg_i.cruise; end_d = now + SHORT_FWD_MS;
        run_d = 1'b1; chg = 1'b1;
      end
    end

    // obstacle check; right side reads as a fixed distance
    obstacle = (item_i.dist_left_cm < cfg_i.threshold) ||
               (item_i.dist_center_cm < cfg_i.threshold) ||
               (RIGHT_DIST_CM < cfg_i.threshold);
    if (obstacle && !avoid_d) begin
      run_d      = 1'b0;
      mode_d     = MODE_STOP;
      chg        = 1'b1;
      avoid_d    = 1'b1;
      early_d    = 1'b1;
      step_d     = STEP_BACKUP;
      step_end_d = now;
    end

    // avoidance sequence
    step_done = (now >= step_end_d) && !run_d;
    if (avoid_d) begin
      case (step_d) inside
        STEP_BACKUP: begin
          mode_d = MODE_BACK; speed_d = cfg_i.cruise; end_d = now + BACKUP_MS;
          run_d = 1'b1; chg = 1'b1;
          step_end_d = now + BACKUP_MS;
          step_d     = STEP_BACKUP_WAIT;
        end
        STEP_BACKUP_WAIT, STEP_TURN_R_WAIT, STEP_TURN_L_WAIT, STEP_FWD_SHRT_WT: begin
          if (step_done) step_d = step_d + 4'd1;
        end
        STEP_TURN_R: begin
          mode_d = MODE_SPIN_RIGHT; speed_d = TURN_SPEED; end_d = now + turn32;
          run_d = 1'b1; chg = 1'b1;
          step_end_d = now + turn32;
          step_d     = STEP_TURN_R_WAIT;
        end
        STEP_FWD_LONG: begin
          early_d = 1'b0;
          mode_d = MODE_FWD; speed_d = cfg_i.cruise; end_d = now + LONG_FWD_MS;
          run_d = 1'b1; chg = 1'b1;
          step_end_d = now + LONG_FWD_WAIT;
          step_d     = STEP_FWD_LONG_WT;
        end
        STEP_FWD_LONG_WT: begin
          if (step_done) begin
            mode_d = MODE_SPIN_LEFT; speed_d = TURN_SPEED;
            end_d = now + turn32 + LEFT_EXTRA_MS;
            run_d = 1'b1; chg = 1'b1;
            step_end_d = now + turn32 + LEFT_EXTRA_MS;
            step_d     = STEP_TURN_L_WAIT;
          end
        end
        STEP_FWD_SHORT: begin
          mode_d = MODE_FWD; speed_d = cfg_i.cruise; end_d = now + SHORT_FWD_MS;
          run_d = 1'b1; chg = 1'b1;
          step_end_d = now + SHORT_FWD_MS;
          step_d     = STEP_FWD_SHRT_WT;
        end
        STEP_FINAL_WAIT: begin
          if (step_done) begin
            early_d = 1'b0;
            avoid_d = 1'b0;
            mode_d = MODE_FWD; speed_d = cfg_i.slow; end_d = now + SLOW_FWD_MS;
            run_d = 1'b1; chg = 1'b1;
            step_end_d = now + SLOW_FWD_MS;
          end
        end
        default: avoid_d = 1'b0;
      endcase
    end

    res_o.motor_mode      = mode_d;
    res_o.motor_speed     = speed_d;
    res_o.moving          = run_d;
    res_o.command_changed = chg;
    res_o.avoiding        = avoid_d;
    res_o.sequence_step   = step_d;
  end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the line-follow / obstacle-avoid sequencer.
`timescale 1ns / 100ps

module tb_top;
  import lfoas_pkg::*;

  // Receiver behaviors: always ready, random stalls, or a repeating ready/stall pattern
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  // One row of the directed part; cmd is compared only where pinned is set
  typedef struct {
    logic [31:0] now;
    logic        r;
    logic        m;
    logic        l;
    logic [9:0]  dl;
    logic [9:0]  dc;
    logic        pinned;
    result_t     cmd;
  } pass_row_t;

  // Typed expectation traveling with each offered item
  typedef struct packed {
    logic    pinned;
    result_t cmd;
  } pin_t;

  localparam int          N_DIR       = 22;
  localparam int          HOLD_CYCLES = 80;
  localparam int          LAT_SLACK   = 4;
  localparam logic [9:0]  FAR         = 10'd1023;
  localparam logic [2:0]  REG_UNUSED  = 3'd5;
  localparam result_t     IDLE_CMD    = '{MODE_STOP, 8'd0, 1'b0, 1'b0, 1'b0, STEP_BACKUP};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [31:0] now_ms, [32] line_right_black, [33] line_middle_black,
  // [34] line_left_black, [44:35] dist_left_cm, [54:45] dist_center_cm, [55] zero
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] motor_mode, [10:3] motor_speed, [11] moving, [12] command_changed,
  // [13] avoiding, [17:14] sequence_step, [23:18] zero
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_follow_obstacle_avoid_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin : reset_gen
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop: well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: mirror of the sequencer's tuning registers and state
  // ---------------------------------------------------------------------------
  logic [9:0]  thr_cm      = THRESHOLD_RST;
  logic [7:0]  cruise_spd  = CRUISE_RST;
  logic [7:0]  slow_spd    = SLOW_RST;
  logic [15:0] turn_ms     = TURN_RST;
  logic [15:0] line_gap_ms = INTERVAL_RST;

  mode_e       mot_mode  = MODE_STOP;
  logic [7:0]  mot_speed = '0;
  logic [31:0] mot_end   = '0;
  logic        mot_on    = 1'b0;
  logic [31:0] line_last = '0;
  logic        avd_on    = 1'b0;
  logic        avd_early = 1'b0;
  logic [3:0]  avd_step  = STEP_BACKUP;
  logic [31:0] avd_end   = '0;
  logic        cmd_chg   = 1'b0;

  function automatic void start_motion(input mode_e md, input logic [7:0] spd,
                                       input logic [31:0] dur, input logic [31:0] t);
    mot_mode  = md;
    mot_speed = spd;
    mot_end   = t + dur;
    mot_on    = 1'b1;
    cmd_chg   = 1'b1;
  endfunction

  function automatic void stop_motion();
    mot_on   = 1'b0;
    mot_mode = MODE_STOP;
    cmd_chg  = 1'b1;
  endfunction

  // One step of the avoidance sequence; only called while it is active
  function automatic void step_avoidance(input logic [31:0] t);
    logic        done;
    logic [31:0] dur;
    done = (t >= avd_end) && !mot_on;
    dur  = {16'd0, turn_ms};
    case (avd_step) inside
      STEP_BACKUP: begin
        start_motion(MODE_BACK, cruise_spd, BACKUP_MS, t);
        avd_end  = t + BACKUP_MS;
        avd_step = STEP_BACKUP_WAIT;
      end
      STEP_BACKUP_WAIT, STEP_TURN_R_WAIT, STEP_TURN_L_WAIT, STEP_FWD_SHRT_WT: begin
        if (done) avd_step = avd_step + 4'd1;
      end
      STEP_TURN_R: begin
        start_motion(MODE_SPIN_RIGHT, TURN_SPEED, dur, t);
        avd_end  = t + dur;
        avd_step = STEP_TURN_R_WAIT;
      end
      STEP_FWD_LONG: begin
        // line corrector comes back from here on
        avd_early = 1'b0;
        start_motion(MODE_FWD, cruise_spd, LONG_FWD_MS, t);
        avd_end  = t + LONG_FWD_WAIT;
        avd_step = STEP_FWD_LONG_WT;
      end
      STEP_FWD_LONG_WT: begin
        if (done) begin
          dur = dur + LEFT_EXTRA_MS;
          start_motion(MODE_SPIN_LEFT, TURN_SPEED, dur, t);
          avd_end  = t + dur;
          avd_step = STEP_TURN_L_WAIT;
        end
      end
      STEP_FWD_SHORT: begin
        start_motion(MODE_FWD, cruise_spd, SHORT_FWD_MS, t);
        avd_end  = t + SHORT_FWD_MS;
        avd_step = STEP_FWD_SHRT_WT;
      end
      STEP_FINAL_WAIT: begin
        // sequence ends; step number stays at the last step
        if (done) begin
          avd_early = 1'b0;
          avd_on    = 1'b0;
          start_motion(MODE_FWD, slow_spd, SLOW_FWD_MS, t);
          avd_end = t + SLOW_FWD_MS;
        end
      end
      default: avd_on = 1'b0;
    endcase
  endfunction

  function automatic result_t predict_motor_cmd(input logic [55:0] d);
    logic [31:0] t;
    logic [31:0] since;
    logic        r;
    logic        m;
    logic        l;
    logic [9:0]  dl;
    logic [9:0]  dc;
    logic [9:0]  dmin;
    result_t     res;
    t  = d[31:0];
    r  = d[32];
    m  = d[33];
    l  = d[34];
    dl = d[44:35];
    dc = d[54:45];
    cmd_chg = 1'b0;

    // timed motion expiry: plain unsigned compare, no wrap handling
    if (mot_on && t >= mot_end) stop_motion();

    // line corrector, throttled on the wrapped time difference
    if (!avd_early) begin
      since = t - line_last;
      if (since >= {16'd0, line_gap_ms}) begin
        line_last = t;
        if (r) start_motion(MODE_SPIN_RIGHT, TURN_SPEED, RIGHT_FIX_MS, t);
        else if (m) begin
          if (!mot_on || mot_mode != MODE_FWD)
            start_motion(MODE_FWD, cruise_spd, SHORT_FWD_MS, t);
        end else if (l) start_motion(MODE_SPIN_LEFT, LEFT_FIX_SPEED, LEFT_FIX_MS, t);
        else if (!mot_on && !avd_on) start_motion(MODE_VEER_LEFT, cruise_spd, SHORT_FWD_MS, t);
      end
    end

    // right sensor is fixed, so the nearest distance never exceeds it
    dmin = RIGHT_DIST_CM;
    if (dl < dmin) dmin = dl;
    if (dc < dmin) dmin = dc;
    if (dmin < thr_cm && !avd_on) begin
      stop_motion();
      avd_on    = 1'b1;
      avd_early = 1'b1;
      avd_step  = STEP_BACKUP;
      avd_end   = t;
    end

    if (avd_on) step_avoidance(t);

    res.motor_mode      = mot_mode;
    res.motor_speed     = mot_speed;
    res.moving          = mot_on;
    res.command_changed = cmd_chg;
    res.avoiding        = avd_on;
    res.sequence_step   = avd_step;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  pin_t    pin_q[$];
  result_t cmd_q[$];
  int      errs = 0;
  int      items_sent = 0;
  int      results_seen = 0;

  function automatic void check_cmd(input result_t want, input result_t got);
    if (got.motor_mode !== want.motor_mode) begin
      $error("motor_mode: expected %0d, got %0d", want.motor_mode, got.motor_mode);
      errs++;
    end
    if (got.motor_speed !== want.motor_speed) begin
      $error("motor_speed: expected %0d, got %0d", want.motor_speed, got.motor_speed);
      errs++;
    end
    if (got.moving !== want.moving) begin
      $error("moving: expected %0b, got %0b", want.moving, got.moving);
      errs++;
    end
    if (got.command_changed !== want.command_changed) begin
      $error("command_changed: expected %0b, got %0b", want.command_changed,
             got.command_changed);
      errs++;
    end
    if (got.avoiding !== want.avoiding) begin
      $error("avoiding: expected %0b, got %0b", want.avoiding, got.avoiding);
      errs++;
    end
    if (got.sequence_step !== want.sequence_step) begin
      $error("sequence_step: expected %0d, got %0d", want.sequence_step, got.sequence_step);
      errs++;
    end
  endfunction

  // Predict on input accept, compare on output accept; both sampled at the edge
  always @(posedge clk_i) begin : scoreboard
    pin_t    pin;
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_motor_cmd(s_axis_tdata);
        pin  = pin_q.pop_front();
        cmd_q.push_back(pin.pinned ? pin.cmd : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.motor_mode      = mode_e'(m_axis_tdata[2:0]);
        got.motor_speed     = m_axis_tdata[10:3];
        got.moving          = m_axis_tdata[11];
        got.command_changed = m_axis_tdata[12];
        got.avoiding        = m_axis_tdata[13];
        got.sequence_step   = m_axis_tdata[17:14];
        if (cmd_q.size() == 0) begin
          $error("motor command with no item pending: %h", m_axis_tdata);
          errs++;
        end else begin
          check_cmd(cmd_q.pop_front(), got);
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern plus long hold-offs on request
  // ---------------------------------------------------------------------------
  sink_mode_e sink_mode = SINK_OPEN;
  logic       hold_tog  = 1'b0;
  logic       hold_ack  = 1'b0;
  int         hold_left = 0;
  logic [7:0] sink_tick = '0;

  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 8'd1;
    if (hold_tog != hold_ack) begin
      hold_ack      <= hold_tog;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN:   m_axis_tready <= 1'b1;
        SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 99) >= 35);
        default:     m_axis_tready <= ((sink_tick % 11) < 6);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------
  int          gap_max    = 0;
  int          burst_left = 0;
  logic [31:0] sim_ms     = '0;   // robot clock for well-formed passes
  pass_row_t   dir_rows[N_DIR];

  function automatic logic [55:0] pack_pass(input logic [31:0] t, input logic r,
                                            input logic m, input logic l,
                                            input logic [9:0] dl, input logic [9:0] dc);
    return {1'b0, dc, dl, l, m, r, t};
  endfunction

  // Offer one item, hold it until taken, then maybe open a gap
  task automatic offer_pass(input logic [55:0] d, input logic pinned, input result_t cmd);
    pin_q.push_back('{pinned, cmd});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && gap_max > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Sender pauses until every result is back, plus pipeline slack
  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (LAT_SLACK) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write, mirror into the predictor, read back the masked value of a mapped register
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    logic [31:0] rd;
    want = '0;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_THRESHOLD: begin thr_cm      = val[9:0];  want = {22'd0, val[9:0]};  end
      REG_CRUISE:    begin cruise_spd  = val[7:0];  want = {24'd0, val[7:0]};  end
      REG_SLOW:      begin slow_spd    = val[7:0];  want = {24'd0, val[7:0]};  end
      REG_TURN:      begin turn_ms     = val[15:0]; want = {16'd0, val[15:0]}; end
      REG_INTERVAL:  begin line_gap_ms = val[15:0]; want = {16'd0, val[15:0]}; end
      default: ;
    endcase
    if (idx <= REG_INTERVAL) begin
      apb_xfer(1'b0, idx, '0, rd);
      if (rd !== want) begin
        $error("register %0d readback: expected %0h, got %0h", idx, want, rd);
        errs++;
      end
    end
  endtask

  // Upper bits carry junk; the block keeps only each register's width
  task automatic apply_cfg(input logic [9:0] thr, input logic [7:0] cruise,
                           input logic [7:0] slow, input logic [15:0] turn,
                           input logic [15:0] gap);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_THRESHOLD, {junk[31:10], thr});
    write_reg(REG_CRUISE,    {junk[31:8], cruise});
    write_reg(REG_SLOW,      {junk[23:0], slow});
    write_reg(REG_TURN,      {junk[31:16], turn});
    write_reg(REG_INTERVAL,  {junk[15:0], gap});
  endtask

  // Mostly a clock moving forward with plausible sensor data; a few noise passes
  function automatic logic [55:0] next_pass(input int unsigned step_max);
    logic [31:0] t;
    logic [9:0]  dl;
    logic [9:0]  dc;
    logic        r;
    logic        m;
    logic        l;
    int unsigned near;
    near = (thr_cm > 10'd1013) ? 1023 : int'(thr_cm) + 10;
    if ($urandom_range(0, 99) < 5) begin
      t  = $urandom();
      r  = 1'($urandom_range(0, 1));
      m  = 1'($urandom_range(0, 1));
      l  = 1'($urandom_range(0, 1));
      dl = 10'($urandom_range(0, 1023));
      dc = 10'($urandom_range(0, 1023));
    end else begin
      sim_ms = sim_ms + $urandom_range(0, step_max);
      t  = sim_ms;
      r  = ($urandom_range(0, 99) < 15);
      m  = ($urandom_range(0, 99) < 15);
      l  = ($urandom_range(0, 99) < 15);
      dl = ($urandom_range(0, 99) < 4) ? 10'($urandom_range(0, near)) :
                                         10'($urandom_range(0, 1023));
      dc = ($urandom_range(0, 99) < 4) ? 10'($urandom_range(0, near)) :
                                         10'($urandom_range(0, 1023));
    end
    return pack_pass(t, r, m, l, dl, dc);
  endfunction

  task automatic run_phase(input int n, input int unsigned step_max, input sink_mode_e sm,
                           input int gmax, input logic hold);
    int i;
    sink_mode <= sm;
    gap_max = gmax;
    // sometimes restart the clock far away or just short of the wrap
    case ($urandom_range(0, 3))
      0: sim_ms = $urandom();
      1: sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      default: ;
    endcase
    if (hold) hold_tog <= ~hold_tog;
    for (i = 0; i < n; i++) begin
      if (i == n / 2) await_drain();
      offer_pass(next_pass(step_max), 1'b0, IDLE_CMD);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int i;
    // Directed walk at reset settings: each line case, the full avoidance
    // sequence, distances at and below the threshold, the time wrap
    dir_rows[0]  = '{32'd0,    1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b1, IDLE_CMD};
    dir_rows[1]  = '{32'd30,   1'b1, 1'b0, 1'b0, FAR,   FAR,   1'b1,
                     '{MODE_SPIN_RIGHT, 8'd200, 1'b1, 1'b1, 1'b0, STEP_BACKUP}};
    dir_rows[2]  = '{32'd60,   1'b0, 1'b1, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[3]  = '{32'd90,   1'b0, 1'b0, 1'b1, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[4]  = '{32'd100,  1'b0, 1'b1, 1'b0, 10'd512, 10'd512, 1'b0, IDLE_CMD};
    dir_rows[5]  = '{32'd400,  1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    // obstacle at zero distance: back up at cruise speed
    dir_rows[6]  = '{32'd401,  1'b0, 1'b0, 1'b0, 10'd0, FAR,   1'b1,
                     '{MODE_BACK, 8'd180, 1'b1, 1'b1, 1'b1, STEP_BACKUP_WAIT}};
    // line bits ignored during the early steps
    dir_rows[7]  = '{32'd700,  1'b1, 1'b1, 1'b1, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[8]  = '{32'd901,  1'b0, 1'b0, 1'b0, FAR,   10'd24, 1'b0, IDLE_CMD};
    dir_rows[9]  = '{32'd902,  1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[10] = '{32'd1302, 1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[11] = '{32'd1303, 1'b0, 1'b0, 1'b0, 10'd25, 10'd25, 1'b0, IDLE_CMD};
    dir_rows[12] = '{32'd2303, 1'b0, 1'b1, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[13] = '{32'd2403, 1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[14] = '{32'd2853, 1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[15] = '{32'd2854, 1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    dir_rows[16] = '{32'd3054, 1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    // last step ends the sequence with a slow forward
    dir_rows[17] = '{32'd3055, 1'b0, 1'b0, 1'b0, FAR,   FAR,   1'b0, IDLE_CMD};
    // near the wrap: end time wraps past zero, unsigned compare expires at once
    dir_rows[18] = '{32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1, FAR, FAR, 1'b0, IDLE_CMD};
    dir_rows[19] = '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, FAR, FAR, 1'b0, IDLE_CMD};
    dir_rows[20] = '{32'h0000_0020, 1'b1, 1'b0, 1'b0, FAR, FAR, 1'b0, IDLE_CMD};
    dir_rows[21] = '{32'h0000_0021, 1'b0, 1'b0, 1'b0, FAR, 10'd0, 1'b0, IDLE_CMD};

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    sink_mode <= SINK_RANDOM;
    gap_max = 2;
    for (i = 0; i < N_DIR; i++)
      offer_pass(pack_pass(dir_rows[i].now, dir_rows[i].r, dir_rows[i].m, dir_rows[i].l,
                           dir_rows[i].dl, dir_rows[i].dc),
                 dir_rows[i].pinned, dir_rows[i].cmd);
    await_drain();

    // reset settings, with a long output hold-off so the input side backs up
    run_phase(150, 60, SINK_RANDOM, 3, 1'b1);
    await_drain();

    // low extremes: never avoid, line check every pass, zero-length turns
    apply_cfg(10'd0, 8'd0, 8'd255, 16'd0, 16'd0);
    write_reg(REG_UNUSED, $urandom());
    run_phase(100, 40, SINK_OPEN, 0, 1'b0);
    await_drain();

    // high extremes: always avoid when idle, longest turns and check interval
    apply_cfg(10'd1023, 8'd255, 8'd0, 16'd65535, 16'd65535);
    run_phase(120, 9000, SINK_PATTERN, 2, 1'b0);
    await_drain();

    for (i = 0; i < 4; i++) begin
      apply_cfg(($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) :
                                              10'($urandom_range(5, 60)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 900)), 16'($urandom_range(0, 120)));
      run_phase(110, 80, sink_mode_e'($urandom_range(0, 2)), $urandom_range(0, 4), 1'b0);
      await_drain();
    end

    if (errs == 0 && cmd_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
